// ----- rtl/dpsq_pkg.sv -----
`timescale 1ns / 1ps

package dpsq_pkg;

  localparam int NUM_W      = 32;
  localparam int AMT_W      = 20;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CODE_W     = 2;

  typedef enum logic [CODE_W-1:0] {
    OP_ARRIVE        = 2'd0,
    OP_SERVE_OLDEST  = 2'd1,
    OP_SERVE_RICHEST = 2'd2
  } op_e;

  typedef enum logic [CODE_W-1:0] {
    ST_SERVED   = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FIN
  } fsm_e;

  typedef struct packed {
    logic             mark;
    logic [AMT_W-1:0] amount;
  } slot_t;

endpackage

// ----- rtl/dpsq_ram.sv -----
`timescale 1ns / 1ps

module dpsq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  dpsq_pkg::slot_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output dpsq_pkg::slot_t rdata_o
);
  import dpsq_pkg::*;

  slot_t mem [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dpsq_scan.sv -----
`timescale 1ns / 1ps

module dpsq_scan #(
  parameter int OW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            vld_i,
  input  logic [OW-1:0]   off_i,
  input  dpsq_pkg::slot_t entry_i,
  output logic [OW-1:0]   best_off_o,
  output logic            first_found_o,
  output logic [OW-1:0]   first_off_o
);
  import dpsq_pkg::*;

  logic             found_q, found_d;
  logic             ffound_q, ffound_d;
  logic [AMT_W-1:0] best_amt_q, best_amt_d;
  logic [OW-1:0]    best_off_q, best_off_d;
  logic [OW-1:0]    first_q, first_d;

  always_comb begin
    found_d    = found_q;
    ffound_d   = ffound_q;
    best_amt_d = best_amt_q;
    best_off_d = best_off_q;
    first_d    = first_q;
    if (clr_i) begin
      found_d  = 1'b0;
      ffound_d = 1'b0;
    end else if (vld_i && entry_i.mark) begin
      // strict compare keeps the lowest number on a tie
      if (!found_q || (entry_i.amount > best_amt_q)) begin
        found_d    = 1'b1;
        best_amt_d = entry_i.amount;
        best_off_d = off_i;
      end
      // first waiting entry behind the oldest one
      if ((off_i != '0) && !ffound_q) begin
        ffound_d = 1'b1;
        first_d  = off_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      ffound_q <= 1'b0;
    end else begin
      found_q  <= found_d;
      ffound_q <= ffound_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_amt_q <= best_amt_d;
    best_off_q <= best_off_d;
    first_q    <= first_d;
  end

  assign best_off_o    = best_off_q;
  assign first_found_o = ffound_q;
  assign first_off_o   = first_q;

endmodule

// ----- rtl/dual_policy_service_queue_top.sv -----
`timescale 1ns / 1ps

// Service queue with two removal policies over one ring of DEPTH slots held in a
// single-port-read synchronous RAM. Operation code in s_axis_tuser: arrival stores
// the amount under the next arrival number (starting at 1, wrapping at 32 bits),
// serve-oldest removes the lowest waiting number, serve-richest removes the
// greatest amount (ties to the lowest number). One result beat per input beat:
// served number in m_axis_tdata (zero unless served) and status in m_axis_tuser.
// An arrival, a refused arrival, a serve on an empty store or an unused code
// is answered straight from the idle state. A serve reads every slot of the
// waiting window (at most DEPTH slots) once through the RAM read port, which
// also finds the next oldest entry, then writes the removal back. One item is in
// work at a time; the input is taken while the block is idle and the result
// register is free or draining. No clearing pass after reset: only slots inside
// the window are ever scanned, and each of them was written by its arrival.
module dual_policy_service_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dpsq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [19:0] amount, [23:20] zero
  input  logic [dpsq_pkg::CODE_W-1:0]     s_axis_tuser,  // [1:0] operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dpsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] served_number
  output logic [dpsq_pkg::CODE_W-1:0]     m_axis_tuser   // [1:0] status
);
  import dpsq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_OFF = OW'(DEPTH);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [OW-1:0] off);
    logic [OW:0] s;
    s = (OW+1)'(base) + (OW+1)'(off);
    if (s >= (OW+1)'(DEPTH)) begin
      s = s - (OW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fsm_e             state_q, state_d;
  logic [NUM_W-1:0] next_q, next_d;
  logic [NUM_W-1:0] oldest_q, oldest_d;
  logic [AW-1:0]    oslot_q, oslot_d;
  logic [OW-1:0]    span_q, span_d;
  logic             rich_q, rich_d;
  logic [OW-1:0]    rd_off_q, rd_off_d;
  logic             pvld_q, pvld_d;
  logic [OW-1:0]    poff_q, poff_d;
  logic             out_vld_q, out_vld_d;
  logic [NUM_W-1:0] out_num_q, out_num_d;
  status_e          out_st_q, out_st_d;

  logic [NUM_W-1:0] diff;
  logic [OW-1:0]    span_w;
  logic             out_free;
  logic             in_acc;
  op_e              op;
  logic [OW-1:0]    best;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  slot_t            mem_wdata;
  logic [AW-1:0]    mem_raddr;
  slot_t            mem_rdata;

  logic             scan_clr;
  logic [OW-1:0]    scan_best;
  logic             scan_ffound;
  logic [OW-1:0]    scan_first;

  // window never exceeds DEPTH, so the low bits of the difference hold the span
  assign diff     = next_q - oldest_q;
  assign span_w   = diff[OW-1:0];
  assign out_free = !out_vld_q || m_axis_tready;
  assign op       = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == FSM_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mem_raddr     = slot_of(oslot_q, rd_off_q);

  always_comb begin
    state_d   = state_q;
    next_d    = next_q;
    oldest_d  = oldest_q;
    oslot_d   = oslot_q;
    span_d    = span_q;
    rich_d    = rich_q;
    rd_off_d  = rd_off_q;
    pvld_d    = 1'b0;
    poff_d    = poff_q;
    out_vld_d = out_vld_q;
    out_num_d = out_num_q;
    out_st_d  = out_st_q;
    mem_we    = 1'b0;
    mem_waddr = slot_of(oslot_q, span_w);
    mem_wdata = '0;
    scan_clr  = 1'b0;
    best      = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_ARRIVE: begin
              out_vld_d = 1'b1;
              out_num_d = '0;
              if (span_w >= DEPTH_OFF) begin
                out_st_d = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_wdata.mark   = 1'b1;
                mem_wdata.amount = s_axis_tdata[AMT_W-1:0];
                next_d           = next_q + 1'b1;
                out_st_d         = ST_ACCEPTED;
              end
            end
            OP_SERVE_OLDEST, OP_SERVE_RICHEST: begin
              if (span_w == '0) begin
                out_vld_d = 1'b1;
                out_num_d = '0;
                out_st_d  = ST_EMPTY;
              end else begin
                span_d   = span_w;
                rich_d   = (op == OP_SERVE_RICHEST);
                rd_off_d = '0;
                scan_clr = 1'b1;
                state_d  = FSM_SCAN;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              out_num_d = '0;
              out_st_d  = ST_EMPTY;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        poff_d = rd_off_q;
        if (rd_off_q != span_q) begin
          pvld_d   = 1'b1;
          rd_off_d = rd_off_q + 1'b1;
        end else if (!pvld_q) begin
          state_d = FSM_FIN;
        end
      end
      FSM_FIN: begin
        if (out_free) begin
          best      = rich_q ? scan_best : '0;
          mem_we    = 1'b1;
          mem_waddr = slot_of(oslot_q, best);
          out_vld_d = 1'b1;
          out_num_d = oldest_q + NUM_W'(best);
          out_st_d  = ST_SERVED;
          // removing the oldest entry moves the window start to the next waiter, or to the next number if none waits
          if (best == '0) begin
            if (scan_ffound) begin
              oldest_d = oldest_q + NUM_W'(scan_first);
              oslot_d  = slot_of(oslot_q, scan_first);
            end else begin
              oldest_d = next_q;
              oslot_d  = slot_of(oslot_q, span_q);
            end
          end
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      next_q    <= NUM_W'(1);
      oldest_q  <= NUM_W'(1);
      oslot_q   <= '0;
      pvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_q    <= next_d;
      oldest_q  <= oldest_d;
      oslot_q   <= oslot_d;
      pvld_q    <= pvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q    <= span_d;
    rich_q    <= rich_d;
    rd_off_q  <= rd_off_d;
    poff_q    <= poff_d;
    out_num_q <= out_num_d;
    out_st_q  <= out_st_d;
  end

  dpsq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dpsq_scan #(
    .OW (OW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clr_i         (scan_clr),
    .vld_i         (pvld_q),
    .off_i         (poff_q),
    .entry_i       (mem_rdata),
    .best_off_o    (scan_best),
    .first_found_o (scan_ffound),
    .first_off_o   (scan_first)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_num_q;
  assign m_axis_tuser  = out_st_q;

endmodule

// ----- rtl/dpsq_checker.sv -----
`timescale 1ns / 1ps

module dpsq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [dpsq_pkg::CODE_W-1:0]     s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dpsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [dpsq_pkg::CODE_W-1:0]     m_axis_tuser
);
  import dpsq_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_zero_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_SERVED) || (m_axis_tdata == '0))
    else $error("nonzero number without served status");

  a_arrive_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == OP_ARRIVE) |=>
      m_axis_tvalid && ((m_axis_tuser == ST_ACCEPTED) || (m_axis_tuser == ST_FULL)))
    else $error("arrival did not answer in the next cycle");

  a_no_take_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result register is blocked");

endmodule

bind dual_policy_service_queue_top dpsq_checker u_dpsq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dpsq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};
  localparam logic [CODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [NUM_W-1:0] number;
    status_e          status;
  } reply_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [CODE_W-1:0]     m_axis_tuser;

  // shadow of the queue contents
  logic [AMT_W-1:0] slot_amount [DEPTH];
  bit               slot_waiting[DEPTH];
  logic [NUM_W-1:0] next_num;
  logic [NUM_W-1:0] oldest_num;
  int               oldest_idx;

  reply_t awaited_replies[$];
  int     err_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;

  dual_policy_service_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Update the shadow queue for one accepted request and return its reply.
  function automatic reply_t apply_request(input logic [CODE_W-1:0] op,
                                           input logic [AMT_W-1:0] amt);
    reply_t           r;
    logic [NUM_W-1:0] span;
    logic [NUM_W-1:0] k;
    logic [NUM_W-1:0] best;
    logic [AMT_W-1:0] best_amt;
    bit               found;
    int               idx;
    int               steps;
    r.number = '0;
    r.status = ST_EMPTY;
    span = next_num - oldest_num;
    if (op == OP_ARRIVE) begin
      if (span >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        idx = (oldest_idx + span) % DEPTH;
        slot_amount[idx]  = amt;
        slot_waiting[idx] = 1'b1;
        next_num = next_num + 1;
        r.status = ST_ACCEPTED;
      end
    end else if (op == OP_SERVE_OLDEST || op == OP_SERVE_RICHEST) begin
      if (span != 0 && span <= DEPTH) begin
        best = '0;
        best_amt = '0;
        found = 1'b0;
        if (op == OP_SERVE_RICHEST) begin
          for (k = 0; k < span; k++) begin
            idx = (oldest_idx + k) % DEPTH;
            // strict compare keeps the lowest number on a tie
            if (slot_waiting[idx] && (!found || slot_amount[idx] > best_amt)) begin
              found = 1'b1;
              best_amt = slot_amount[idx];
              best = k;
            end
          end
        end
        slot_waiting[(oldest_idx + best) % DEPTH] = 1'b0;
        r.number = oldest_num + best;
        r.status = ST_SERVED;
        // skip holes left by earlier removals
        steps = 0;
        while (oldest_num != next_num && steps < DEPTH && !slot_waiting[oldest_idx]) begin
          oldest_num = oldest_num + 1;
          oldest_idx = (oldest_idx + 1) % DEPTH;
          steps++;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    logic [AMT_W-1:0] a;
    case ($urandom_range(3))
      0: a = $urandom();
      1: a = $urandom_range(3);
      2: a = $urandom_range(1) ? AMT_MAX : '0;
      default: a = AMT_MAX >> $urandom_range(AMT_W - 1);
    endcase
    return a;
  endfunction

  task automatic offer_request(input logic [CODE_W-1:0] op, input logic [AMT_W-1:0] amt);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {{(IN_DATA_W - AMT_W){1'b0}}, amt};
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_replies.push_back(apply_request(op, amt));
  endtask

  task automatic pause_sender();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    pause_sender();
    while (awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: a pending long hold wins over random stalls.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: unexpected beat number=%0d status=%0d", m_axis_tdata, m_axis_tuser);
      end else begin
        want = awaited_replies.pop_front();
        if (m_axis_tdata !== want.number || m_axis_tuser !== want.status) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: number exp %0d got %0d, status exp %0d got %0d",
                     want.number, m_axis_tdata, want.status, m_axis_tuser);
        end
      end
    end
  end

  task automatic test_empty_and_unused();
    offer_request(OP_SERVE_OLDEST, AMT_MAX);
    offer_request(OP_SERVE_RICHEST, '0);
    offer_request(OP_UNUSED, 20'h5A5A5);
    offer_request(OP_ARRIVE, '0);
    offer_request(OP_SERVE_RICHEST, '0);
    offer_request(OP_SERVE_OLDEST, '0);
  endtask

  task automatic test_ties_and_holes();
    offer_request(OP_ARRIVE, AMT_MAX);
    offer_request(OP_ARRIVE, 20'd5);
    offer_request(OP_ARRIVE, AMT_MAX);
    offer_request(OP_ARRIVE, '0);
    offer_request(OP_ARRIVE, 20'd5);
    offer_request(OP_ARRIVE, 20'hAAAAA);
    offer_request(OP_ARRIVE, 20'h55555);
    offer_request(OP_SERVE_RICHEST, '0);
    offer_request(OP_SERVE_RICHEST, '0);
    offer_request(OP_SERVE_RICHEST, '0);
    offer_request(OP_SERVE_OLDEST, '0);
    offer_request(OP_SERVE_RICHEST, '0);
    offer_request(OP_SERVE_OLDEST, '0);
    offer_request(OP_SERVE_OLDEST, '0);
    offer_request(OP_SERVE_OLDEST, '0);
    offer_request(OP_SERVE_RICHEST, '0);
    wait_drained();
  endtask

  // Stall the receiver, overfill the ring so it refuses, then serve past empty.
  task automatic test_fill_under_backpressure();
    int n;
    hold_left = 500;
    for (n = 0; n < DEPTH + 6; n++)
      offer_request(OP_ARRIVE, pick_amount());
    wait_drained();
    for (n = 0; n < DEPTH + 2; n++)
      offer_request($urandom_range(1) ? OP_SERVE_OLDEST : OP_SERVE_RICHEST, pick_amount());
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int count);
    int               sent;
    int               mode;
    int               burst;
    int               n;
    int               pick;
    logic [CODE_W-1:0] op;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(9);
      burst = (mode < 3) ? $urandom_range(1, DEPTH + 6) : $urandom_range(1, 24);
      for (n = 0; n < burst; n++) begin
        pick = $urandom_range(99);
        if (mode < 3)
          op = OP_ARRIVE;
        else if (mode < 6)
          op = (pick < 50) ? OP_SERVE_OLDEST : OP_SERVE_RICHEST;
        else if (mode < 9)
          op = (pick < 50) ? OP_ARRIVE : (pick < 75) ? OP_SERVE_OLDEST : OP_SERVE_RICHEST;
        else
          op = $urandom_range(3);
        offer_request(op, pick_amount());
        if (op != OP_UNUSED)
          sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_amount[i]  = '0;
      slot_waiting[i] = 1'b0;
    end
    next_num   = 1;
    oldest_num = 1;
    oldest_idx = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_unused();
    test_ties_and_holes();
    test_fill_under_backpressure();
    test_random_traffic(0, 0, 160);
    test_random_traffic(67, 0, 160);
    test_random_traffic(0, 67, 160);
    test_random_traffic(30, 30, 160);

    repeat (2 * DEPTH + 8) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      err_count++;
      $display("ERROR: %0d replies never arrived", awaited_replies.size());
    end
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
